// File: src/hrcd_pkg.sv
package hrcd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int CMP_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int NAME_LEN = 18;
  localparam int NAME_POS_BITS = 5;
  localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_WAITING   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_NO_HEADER = 3'd2,
    ST_NO_DIGITS = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // one classified request byte, as passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       is_space;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
    logic       is_cr;
    logic       is_nul;
  } byte_class_t;

  // CR LF "Content-Length: "
  function automatic logic [7:0] name_char(input logic [NAME_POS_BITS-1:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = CH_CR;
      5'd1:    ch = CH_LF;
      5'd2:    ch = 8'h43;
      5'd3:    ch = 8'h6f;
      5'd4:    ch = 8'h6e;
      5'd5:    ch = 8'h74;
      5'd6:    ch = 8'h65;
      5'd7:    ch = 8'h6e;
      5'd8:    ch = 8'h74;
      5'd9:    ch = 8'h2d;
      5'd10:   ch = 8'h4c;
      5'd11:   ch = 8'h65;
      5'd12:   ch = 8'h6e;
      5'd13:   ch = 8'h67;
      5'd14:   ch = 8'h74;
      5'd15:   ch = 8'h68;
      5'd16:   ch = 8'h3a;
      5'd17:   ch = CH_SPACE;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// File: src/hrcd_front.sv
module hrcd_front import hrcd_pkg::*; (
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output byte_class_t cls
);

  always_comb begin
    cls.data     = data_byte;
    cls.first    = first_byte;
    cls.is_space = (data_byte == CH_SPACE) ||
                   (data_byte >= CH_TAB && data_byte <= CH_CR);
    cls.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    cls.is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
    cls.is_minus = (data_byte == CH_MINUS);
    cls.is_cr    = (data_byte == CH_CR);
    cls.is_nul   = (data_byte == CH_NUL);
  end

endmodule

// File: src/hrcd_queue.sv
module hrcd_queue import hrcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  byte_class_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output byte_class_t pop_data
);

  byte_class_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/hrcd_back.sv
module hrcd_back import hrcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  byte_class_t item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] body_offset,
  output logic [31:0] frame_length
);

  logic [31:0]             max_len;
  logic [COUNT_BITS-1:0]   byte_count;
  logic [1:0]              end_match_pos;
  logic                    header_end_seen;
  logic [COUNT_BITS-1:0]   hdr_len;
  logic [NAME_POS_BITS-1:0] name_match_pos;
  logic                    name_seen;
  logic                    search_blocked;
  phase_t                  value_phase;
  logic                    value_negative;
  logic [31:0]             value_accum;
  logic                    value_overflow;
  logic                    digit_seen;

  logic [COUNT_BITS-1:0]   byte_count_next;
  logic [1:0]              end_match_pos_next;
  logic                    header_end_seen_next;
  logic [COUNT_BITS-1:0]   hdr_len_next;
  logic [NAME_POS_BITS-1:0] name_match_pos_next;
  logic                    name_seen_next;
  logic                    search_blocked_next;
  phase_t                  value_phase_next;
  logic                    value_negative_next;
  logic [31:0]             value_accum_next;
  logic                    value_overflow_next;
  logic                    digit_seen_next;

  logic                    fire;
  logic [31:0]             accum_base;
  logic [35:0]             scaled;
  logic [CMP_BITS-1:0]     body_bytes;
  status_t                 status_next;
  logic [31:0]             length_next;

  assign item_ready = out_ready || !out_valid;
  assign fire       = item_valid && item_ready;

  assign accum_base = item.first ? 32'd0 : value_accum;

  // value times ten plus digit, in 36 bits so that overflow shows up top
  assign scaled = {1'b0, accum_base, 3'b000}
                  + {3'b000, accum_base, 1'b0}
                  + {32'd0, item.data[3:0]};

  // state update for one request byte
  always_comb begin
    logic [2:0] end_step;
    logic [7:0] want;

    if (item.first) begin
      byte_count_next     = '0;
      end_match_pos_next  = 2'd0;
      header_end_seen_next = 1'b0;
      hdr_len_next        = '0;
      name_match_pos_next = '0;
      name_seen_next      = 1'b0;
      search_blocked_next = 1'b0;
      value_phase_next    = PH_SKIP;
      value_negative_next = 1'b0;
      value_accum_next    = 32'd0;
      value_overflow_next = 1'b0;
      digit_seen_next     = 1'b0;
    end else begin
      byte_count_next     = byte_count;
      end_match_pos_next  = end_match_pos;
      header_end_seen_next = header_end_seen;
      hdr_len_next        = hdr_len;
      name_match_pos_next = name_match_pos;
      name_seen_next      = name_seen;
      search_blocked_next = search_blocked;
      value_phase_next    = value_phase;
      value_negative_next = value_negative;
      value_accum_next    = value_accum;
      value_overflow_next = value_overflow;
      digit_seen_next     = digit_seen;
    end

    end_step = {1'b0, end_match_pos_next} + 3'd1;
    want     = end_match_pos_next[0] ? CH_LF : CH_CR;

    if (byte_count_next != '1) begin
      byte_count_next = byte_count_next + 1'b1;
    end

    if (!header_end_seen_next) begin
      // value parsing only on bytes after the name has completed
      if (name_seen_next && value_phase_next != PH_DONE) begin
        if (value_phase_next == PH_SKIP && item.is_space) begin
          value_phase_next = PH_SKIP;
        end else if (value_phase_next == PH_SKIP && item.is_sign) begin
          value_negative_next = item.is_minus;
          value_phase_next    = PH_SIGN;
        end else if (!item.is_digit) begin
          value_phase_next = PH_DONE;
        end else begin
          digit_seen_next  = 1'b1;
          value_phase_next = PH_DIGITS;
          if (value_overflow_next || scaled[35:32] != 4'd0) begin
            value_overflow_next = 1'b1;
            value_accum_next    = '1;
          end else begin
            value_accum_next = scaled[31:0];
          end
        end
      end

      if (!name_seen_next && !search_blocked_next) begin
        if (item.is_nul) begin
          search_blocked_next = 1'b1;
          name_match_pos_next = '0;
        end else if (item.data == name_char(name_match_pos_next)) begin
          name_match_pos_next = name_match_pos_next + 1'b1;
          if (name_match_pos_next == NAME_POS_BITS'(NAME_LEN)) begin
            name_seen_next = 1'b1;
          end
        end else begin
          name_match_pos_next = item.is_cr ? NAME_POS_BITS'(1) : '0;
        end
      end

      if (item.data == want) begin
        if (end_step == 3'd4) begin
          end_match_pos_next   = 2'd0;
          header_end_seen_next = 1'b1;
          hdr_len_next         = byte_count_next;
          if (value_phase_next != PH_DIGITS) begin
            value_phase_next = PH_DONE;
          end
        end else begin
          end_match_pos_next = end_step[1:0];
        end
      end else begin
        end_match_pos_next = item.is_cr ? 2'd1 : 2'd0;
      end
    end
  end

  assign body_bytes = CMP_BITS'(byte_count_next) - CMP_BITS'(hdr_len_next);

  // result for the byte, taken from the updated state
  always_comb begin
    status_next = ST_WAITING;
    length_next = 32'd0;
    if (header_end_seen_next) begin
      if (!name_seen_next) begin
        status_next = ST_NO_HEADER;
      end else if (!digit_seen_next) begin
        status_next = ST_NO_DIGITS;
      end else if (value_overflow_next || value_accum_next > max_len ||
                   (value_negative_next && value_accum_next != 32'd0)) begin
        status_next = ST_TOO_LARGE;
      end else if (body_bytes >= CMP_BITS'(value_accum_next)) begin
        status_next = ST_COMPLETE;
        length_next = value_accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len         <= MAX_LEN_RESET;
      byte_count      <= '0;
      end_match_pos   <= 2'd0;
      header_end_seen <= 1'b0;
      hdr_len         <= '0;
      name_match_pos  <= '0;
      name_seen       <= 1'b0;
      search_blocked  <= 1'b0;
      value_phase     <= PH_SKIP;
      value_negative  <= 1'b0;
      value_accum     <= 32'd0;
      value_overflow  <= 1'b0;
      digit_seen      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (fire) begin
        byte_count      <= byte_count_next;
        end_match_pos   <= end_match_pos_next;
        header_end_seen <= header_end_seen_next;
        hdr_len         <= hdr_len_next;
        name_match_pos  <= name_match_pos_next;
        name_seen       <= name_seen_next;
        search_blocked  <= search_blocked_next;
        value_phase     <= value_phase_next;
        value_negative  <= value_negative_next;
        value_accum     <= value_accum_next;
        value_overflow  <= value_overflow_next;
        digit_seen      <= digit_seen_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status       <= status_next;
      body_offset  <= header_end_seen_next ? 32'(hdr_len_next) : 32'd0;
      frame_length <= length_next;
    end
  end

endmodule

// File: src/http_response_completion_detector_core.sv
// HTTP response completion detector, Content-Length framing.
// Input channel: one response byte per request (data_byte), with first_byte
// set on the first byte of each new response to clear the parse state.
// Output channel: one result per input byte: status, body_offset and
// frame_length.
// Configuration: cfg_wr_en with cfg_wr_data writes the length limit in
// the same cycle; write it only while no byte is in flight.
// A byte is classified on acceptance and held in a two-entry queue; the
// back end pops it, updates the header and value matchers and loads the
// output register, which raises out_valid; the queue entry and the output
// register lie between input acceptance and the result.
// Throughput is one byte per cycle while out_ready is high; the matcher and
// accumulator update in the back end is combinational.
// When out_ready is low the output register holds its result, the back end
// stops popping, and the queue fills; in_ready drops once both entries are
// taken, so nothing is lost.
// Reset (rst, synchronous) empties the queue and output register, clears
// all parse state and sets the length limit to 4194304.
module http_response_completion_detector_core import hrcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] body_offset,
  output logic [31:0] frame_length
);

  byte_class_t front_cls;
  byte_class_t queue_cls;
  logic        queue_valid;
  logic        queue_ready;

  hrcd_front u_front (
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .cls        (front_cls)
  );

  hrcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cls),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cls)
  );

  hrcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (queue_valid),
    .item_ready   (queue_ready),
    .item         (queue_cls),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .body_offset  (body_offset),
    .frame_length (frame_length)
  );

endmodule

// File: sim/tb_top.sv
module tb_top import hrcd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } rx_byte_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] body_offset;
    logic [31:0] frame_length;
  } resp_result_t;

  typedef enum int {
    K_PLAIN, K_WHITESPACE, K_PLUS, K_MINUS_ZERO, K_MINUS_VALUE, K_HUGE,
    K_SIGN_SPACE, K_SIGN_ONLY, K_NO_DIGITS, K_NO_NAME, K_NUL_FIRST,
    K_LATE_NAME, K_WRONG_CASE, K_NOISE
  } resp_kind_t;

  localparam logic [8*NAME_LEN-1:0] LEN_NAME = {CH_CR, CH_LF, "Content-Length: "};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] body_offset;
  logic [31:0] frame_length;

  http_response_completion_detector_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .body_offset  (body_offset),
    .frame_length (frame_length)
  );

  always #10 clk = ~clk;

  rx_byte_t     bytes_to_send[$];
  resp_result_t expected_results[$];
  int unsigned  bytes_queued = 0;
  logic         start_flag = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatches = 0;

  // parser state mirrored from the block
  logic [31:0]           max_len = MAX_LEN_RESET;
  logic [COUNT_BITS-1:0] rx_count = '0;
  int unsigned           end_pos = 0;
  logic                  hdr_done = 1'b0;
  logic [COUNT_BITS-1:0] hdr_size = '0;
  int unsigned           name_pos = 0;
  logic                  name_found = 1'b0;
  logic                  search_off = 1'b0;
  phase_t                phase = PH_SKIP;
  logic                  neg = 1'b0;
  logic [31:0]           accum = '0;
  logic                  ovf = 1'b0;
  logic                  saw_digit = 1'b0;

  function automatic resp_result_t step_response(input logic [7:0] c, input logic clr);
    resp_result_t          r;
    logic [7:0]            want;
    logic [31:0]           d;
    logic                  is_sp;
    logic                  is_dig;
    logic [CMP_BITS-1:0]   body_bytes;
    r.status = ST_WAITING;
    r.body_offset = '0;
    r.frame_length = '0;
    is_sp = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 32'(c - CH_ZERO);
    if (clr) begin
      rx_count = '0;
      end_pos = 0;
      hdr_done = 1'b0;
      hdr_size = '0;
      name_pos = 0;
      name_found = 1'b0;
      search_off = 1'b0;
      phase = PH_SKIP;
      neg = 1'b0;
      accum = '0;
      ovf = 1'b0;
      saw_digit = 1'b0;
    end
    if (rx_count != '1) rx_count++;
    if (!hdr_done) begin
      // value bytes only count once the whole name came on earlier bytes
      if (name_found && phase != PH_DONE) begin
        if (phase == PH_SKIP && is_sp) begin
        end else if (phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
          neg = (c == CH_MINUS);
          phase = PH_SIGN;
        end else if (!is_dig) begin
          phase = PH_DONE;
        end else begin
          saw_digit = 1'b1;
          phase = PH_DIGITS;
          if (ovf || accum > (32'hFFFF_FFFF - d) / 32'd10) begin
            ovf = 1'b1;
            accum = 32'hFFFF_FFFF;
          end else begin
            accum = accum * 32'd10 + d;
          end
        end
      end
      if (!name_found && !search_off) begin
        if (c == CH_NUL) begin
          search_off = 1'b1;
          name_pos = 0;
        end else if (name_pos < NAME_LEN &&
                     c == LEN_NAME[8*(NAME_LEN-1-name_pos) +: 8]) begin
          name_pos++;
          if (name_pos == NAME_LEN) name_found = 1'b1;
        end else begin
          name_pos = (c == CH_CR) ? 1 : 0;
        end
      end
      want = end_pos[0] ? CH_LF : CH_CR;
      if (c == want) begin
        end_pos++;
        if (end_pos >= 4) begin
          end_pos = 0;
          hdr_done = 1'b1;
          hdr_size = rx_count;
          if (phase != PH_DIGITS) phase = PH_DONE;
        end
      end else begin
        end_pos = (c == CH_CR) ? 1 : 0;
      end
    end
    if (hdr_done) begin
      r.body_offset = hdr_size[31:0];
      body_bytes = CMP_BITS'(rx_count - hdr_size);
      if (!name_found) begin
        r.status = ST_NO_HEADER;
      end else if (!saw_digit) begin
        r.status = ST_NO_DIGITS;
      end else if (ovf || accum > max_len || (neg && accum != 0)) begin
        r.status = ST_TOO_LARGE;
      end else if (body_bytes >= CMP_BITS'(accum)) begin
        r.status = ST_COMPLETE;
        r.frame_length = accum;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : request_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(step_response(data_byte, first_byte));
        bytes_to_send.delete(0);
      end
      if (!in_valid || in_ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          data_byte <= bytes_to_send[0].data;
          first_byte <= bytes_to_send[0].first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    resp_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, status);
            mismatches++;
          end
          if (body_offset !== exp_r.body_offset) begin
            $error("body_offset expected %0d got %0d", exp_r.body_offset, body_offset);
            mismatches++;
          end
          if (frame_length !== exp_r.frame_length) begin
            $error("frame_length expected %0d got %0d",
                   exp_r.frame_length, frame_length);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    bytes_to_send.push_back('{data: b, first: start_flag});
    start_flag = 1'b0;
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_header_line();
    push_crlf();
    push_text("X-h: ");
    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(97, 122)));
  endtask

  task automatic gen_response(input resp_kind_t k);
    int unsigned v;
    int unsigned body;
    string       digits;
    string       huge;
    v = $urandom_range(0, 40);
    digits = $sformatf("%0d", v);
    body = $urandom_range(0, 6);
    // now and then carry on without a new-response mark
    start_flag = ($urandom_range(9) != 0);
    if (k == K_NOISE) begin
      repeat ($urandom_range(5, 30)) begin
        if ($urandom_range(9) == 0) start_flag = 1'b1;
        case ($urandom_range(7))
          0: push_byte(CH_CR);
          1: push_byte(CH_LF);
          2: push_byte(CH_NUL);
          3: push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
          4: push_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
          default: push_byte(8'($urandom_range(255)));
        endcase
      end
      return;
    end
    push_text("HTTP/1.1 200 OK");
    if (k == K_NUL_FIRST) push_byte(CH_NUL);
    repeat ($urandom_range(0, 2)) push_header_line();
    if (k != K_NO_NAME && k != K_LATE_NAME) begin
      push_crlf();
      push_text(k == K_WRONG_CASE ? "Content-length: " : "Content-Length: ");
      case (k)
        K_WHITESPACE: begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
              0: push_byte(CH_SPACE);
              1: push_byte(CH_TAB);
              2: push_byte(8'h0b);
              default: push_byte(8'h0c);
            endcase
          end
          push_text(digits);
        end
        K_PLUS: push_text({"+", digits});
        K_MINUS_ZERO: push_text($urandom_range(1) ? "-0" : "-00");
        K_MINUS_VALUE: push_text({"-", $sformatf("%0d", $urandom_range(1, 40))});
        K_HUGE: begin
          case ($urandom_range(4))
            0: huge = "4294967295";
            1: huge = "4294967296";
            2: huge = "99999999999";
            3: huge = "4194305";
            default: huge = "4194304";
          endcase
          push_text(huge);
        end
        K_SIGN_SPACE: push_text({"+ ", digits});
        K_SIGN_ONLY: push_text("-");
        K_NO_DIGITS: if ($urandom_range(1)) push_text("abc");
        default: begin
          if ($urandom_range(3) == 0) push_text("00");
          push_text(digits);
          if ($urandom_range(3) == 0) push_text("x9");
        end
      endcase
      if (k == K_PLAIN || k == K_WHITESPACE || k == K_PLUS) begin
        // mostly enough body to finish, sometimes one short
        body = ($urandom_range(4) == 0 && v != 0) ? v - 1 : v + $urandom_range(0, 3);
      end
    end
    repeat ($urandom_range(0, 1)) push_header_line();
    push_crlf();
    push_crlf();
    if (k == K_LATE_NAME) begin
      push_text("Content-Length: 3");
      push_crlf();
    end
    repeat (body) push_byte(8'($urandom_range(255)));
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned target;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      if ($urandom_range(99) < 15) gen_response(K_NOISE);
      else gen_response(resp_kind_t'($urandom_range(0, K_NOISE - 1)));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] cfg_val;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // one response of every shape, reset limit, no idling
    for (int k = 0; k <= K_NOISE; k++) gen_response(resp_kind_t'(k));
    wait_drained();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: cfg_val = 32'd0;
        1: cfg_val = 32'hFFFF_FFFF;
        2: cfg_val = MAX_LEN_RESET;
        3: cfg_val = 32'd20;
        default: cfg_val = $urandom_range(0, 45);
      endcase
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= cfg_val;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      max_len = cfg_val;
      @(negedge clk);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 58; recv_stall_pct = 58; end
      endcase
      fill_random(120);
      wait_drained();
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[http_response_completion_detector_core] OK");
    end else begin
      $display("[http_response_completion_detector_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("[http_response_completion_detector_core] ERROR");
    $finish;
  end

endmodule

// File: http_response_completion_detector_core.f
src/hrcd_pkg.sv
src/hrcd_front.sv
src/hrcd_queue.sv
src/hrcd_back.sv
src/http_response_completion_detector_core.sv
sim/tb_top.sv
